FILE: sv/param_ramp_automation_macros.svh
// assertion macros for the ramp automation checker
`ifndef PARAM_RAMP_AUTOMATION_MACROS_SVH
`define PARAM_RAMP_AUTOMATION_MACROS_SVH

// overlapping implication
`define PRA_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");

// next-cycle implication
`define PRA_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");

`endif

FILE: sv/pra_pkg.sv
// ----------------------------------------------------------------------------
// pra_pkg
// types, constants and codes shared by the ramp automation modules
// ----------------------------------------------------------------------------
package pra_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = 5;
    localparam int FRAC_BITS   = 16;
    localparam int DIV_W       = $clog2(FRAC_BITS);
    localparam int TIME_W      = 48;
    localparam int VAL_W       = 32;
    localparam int SPAN_W      = 24;
    localparam int F_W         = FRAC_BITS + 1;

    localparam logic [2:0] MODE_TICK       = 3'd0;
    localparam logic [2:0] MODE_APPLY      = 3'd1;
    localparam logic [2:0] MODE_APPLY_HELD = 3'd2;
    localparam logic [2:0] MODE_APPEND     = 3'd3;
    localparam logic [2:0] MODE_SET        = 3'd4;
    localparam logic [2:0] MODE_CLEAR      = 3'd5;

    localparam logic [1:0] CURVE_IN  = 2'd1;
    localparam logic [1:0] CURVE_OUT = 2'd2;

    typedef struct packed {
        logic [2:0]               mode;
        logic signed [VAL_W-1:0]  begin_value;
        logic signed [VAL_W-1:0]  end_value;
        logic [SPAN_W-1:0]        delay_samples;
        logic [SPAN_W-1:0]        duration_samples;
        logic [1:0]               curve;
    } t_in_word;

    typedef struct packed {
        logic signed [VAL_W-1:0]  value;
        logic                     ramping;
        logic [CNT_W-1:0]         queued_events;
        logic                     queue_overflow;
        logic [31:0]              remaining_samples;
    } t_out_word;

    typedef struct packed {
        logic load;
        logic prep;
        logic push;
        logic retire;
        logic div_init;
        logic div_step;
        logic mul_f;
        logic mul_p;
        logic ramp;
        logic adv;
        logic fin;
    } t_dp_cmd;

    typedef struct packed {
        logic is_tick;
        logic head_retire;
        logic head_started;
        logic div_last;
    } t_dp_sts;

endpackage

FILE: sv/pra_datapath.sv
// ----------------------------------------------------------------------------
// pra_datapath
// event queue, sample clock, divider and interpolation arithmetic
// ----------------------------------------------------------------------------
module pra_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pra_pkg::t_in_word  i_word,
    input  pra_pkg::t_dp_cmd   i_cmd,
    output pra_pkg::t_dp_sts   o_sts,
    output pra_pkg::t_out_word o_result
);
    import pra_pkg::*;

    typedef struct packed {
        logic [TIME_W-1:0]       start_time;
        logic [TIME_W-1:0]       stop_time;
        logic signed [VAL_W-1:0] from_value;
        logic signed [VAL_W-1:0] to_value;
        logic [1:0]              curve;
    } t_event;

    t_event                  r_mem [QUEUE_DEPTH];
    t_event                  r_rd;
    t_in_word                r_in;
    logic [TIME_W-1:0]       r_clock;
    logic signed [VAL_W-1:0] r_held;
    logic [PTR_W-1:0]        r_head;
    logic [CNT_W-1:0]        r_count;
    logic [TIME_W-1:0]       r_last_stop;
    logic signed [VAL_W-1:0] r_last_to;
    logic [TIME_W-1:0]       r_st;
    logic signed [VAL_W-1:0] r_from;
    logic                    r_push;
    logic                    r_ovf;
    logic                    r_ramping;
    logic [SPAN_W:0]         r_rem;
    logic [SPAN_W-1:0]       r_dur;
    logic [FRAC_BITS-1:0]    r_quo;
    logic [DIV_W-1:0]        r_div_cnt;
    logic [F_W-1:0]          r_f;
    logic signed [VAL_W+F_W:0] r_prod;
    t_out_word               r_result;

    logic [TIME_W:0]         n_st_sum;
    logic [TIME_W:0]         n_stop_sum;
    logic [TIME_W-1:0]       n_stop;
    logic [TIME_W-1:0]       n_base;
    logic signed [VAL_W-1:0] n_from;
    logic [SPAN_W:0]         n_rem2;
    logic [TIME_W-1:0]       n_diff;
    logic [TIME_W-1:0]       n_span;
    logic [2*F_W-1:0]        n_fprod;
    logic signed [VAL_W:0]   n_d;
    logic signed [VAL_W+F_W:0] n_q;
    logic [TIME_W-1:0]       n_left;
    logic [PTR_W-1:0]        n_slot;

    always_comb begin
        n_base = r_clock;
        n_from = r_held;
        case (r_in.mode)
            MODE_APPLY: begin
                n_from = r_in.begin_value;
            end
            MODE_APPEND: begin
                if (r_count != '0) begin
                    n_base = r_last_stop;
                    n_from = r_last_to;
                end
            end
            default: begin
                n_from = r_held;
            end
        endcase
        n_st_sum   = {1'b0, n_base} + {{(TIME_W-SPAN_W+1){1'b0}}, r_in.delay_samples};
        n_stop_sum = {1'b0, r_st} + {{(TIME_W-SPAN_W+1){1'b0}}, r_in.duration_samples};
        n_stop     = n_stop_sum[TIME_W] ? {TIME_W{1'b1}} : n_stop_sum[TIME_W-1:0];
        n_slot     = r_head + r_count[PTR_W-1:0];
        n_rem2     = {r_rem[SPAN_W-1:0], 1'b0};
        n_diff     = r_clock - r_rd.start_time;
        n_span     = r_rd.stop_time - r_rd.start_time;
        case (r_rd.curve)
            CURVE_IN:  n_fprod = {2'b00, r_quo} * {2'b00, r_quo};
            CURVE_OUT: n_fprod = {2'b00, r_quo}
                * ({1'b1, {(F_W){1'b0}}} - {2'b00, r_quo});
            default:   n_fprod = {{(2*F_W-2*FRAC_BITS){1'b0}}, r_quo, {FRAC_BITS{1'b0}}};
        endcase
        n_d    = {r_rd.to_value[VAL_W-1], r_rd.to_value}
               - {r_rd.from_value[VAL_W-1], r_rd.from_value};
        n_q    = r_prod >>> FRAC_BITS;
        n_left = r_last_stop - r_clock;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push && r_push) begin
            r_mem[n_slot] <= '{start_time: r_st, stop_time: n_stop,
                               from_value: r_from, to_value: r_in.end_value,
                               curve: r_in.curve};
        end
        r_rd <= r_mem[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock   <= '0;
            r_held    <= '0;
            r_head    <= '0;
            r_count   <= '0;
            r_push    <= 1'b0;
            r_ovf     <= 1'b0;
            r_ramping <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_in      <= i_word;
                r_push    <= 1'b0;
                r_ovf     <= 1'b0;
                r_ramping <= 1'b0;
            end
            if (i_cmd.prep) begin
                r_st   <= n_st_sum[TIME_W] ? {TIME_W{1'b1}} : n_st_sum[TIME_W-1:0];
                r_from <= n_from;
                case (r_in.mode)
                    MODE_APPLY, MODE_APPLY_HELD: begin
                        r_count <= '0;
                        r_push  <= 1'b1;
                    end
                    MODE_APPEND: begin
                        if (r_count >= CNT_W'(QUEUE_DEPTH)) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_push <= 1'b1;
                        end
                    end
                    MODE_SET: begin
                        r_count <= '0;
                        r_held  <= r_in.begin_value;
                    end
                    MODE_CLEAR: begin
                        r_count <= '0;
                    end
                    default: begin
                        r_push <= 1'b0;
                    end
                endcase
            end
            if (i_cmd.push && r_push) begin
                r_count     <= r_count + 1'b1;
                r_last_stop <= n_stop;
                r_last_to   <= r_in.end_value;
            end
            if (i_cmd.retire) begin
                r_held  <= r_rd.to_value;
                r_head  <= r_head + 1'b1;
                r_count <= r_count - 1'b1;
            end
            if (i_cmd.div_init) begin
                r_rem     <= {1'b0, n_diff[SPAN_W-1:0]};
                r_dur     <= n_span[SPAN_W-1:0];
                r_div_cnt <= '0;
            end
            if (i_cmd.div_step) begin
                if (n_rem2 >= {1'b0, r_dur}) begin
                    r_rem <= n_rem2 - {1'b0, r_dur};
                    r_quo <= {r_quo[FRAC_BITS-2:0], 1'b1};
                end else begin
                    r_rem <= n_rem2;
                    r_quo <= {r_quo[FRAC_BITS-2:0], 1'b0};
                end
                r_div_cnt <= r_div_cnt + 1'b1;
            end
            if (i_cmd.mul_f) begin
                r_f <= n_fprod[FRAC_BITS +: F_W];
            end
            if (i_cmd.mul_p) begin
                r_prod <= n_d * $signed({1'b0, r_f});
            end
            if (i_cmd.ramp) begin
                r_held    <= r_rd.from_value + n_q[VAL_W-1:0];
                r_ramping <= 1'b1;
            end
            if (i_cmd.adv) begin
                r_clock <= r_clock + 1'b1;
            end
            if (i_cmd.fin) begin
                r_result.value          <= r_held;
                r_result.ramping        <= r_ramping;
                r_result.queued_events  <= r_count;
                r_result.queue_overflow <= r_ovf;
                if (r_count == '0 || r_last_stop <= r_clock) begin
                    r_result.remaining_samples <= '0;
                end else if (n_left[TIME_W-1:32] != '0) begin
                    r_result.remaining_samples <= '1;
                end else begin
                    r_result.remaining_samples <= n_left[31:0];
                end
            end
        end
    end

    assign o_sts.is_tick      = (r_in.mode == MODE_TICK);
    assign o_sts.head_retire  = (r_count != '0) && (r_rd.stop_time <= r_clock);
    assign o_sts.head_started = (r_count != '0) && (r_rd.start_time <= r_clock);
    assign o_sts.div_last     = (r_div_cnt == DIV_W'(FRAC_BITS - 1));
    assign o_result           = r_result;

endmodule

FILE: sv/pra_control.sv
// ----------------------------------------------------------------------------
// pra_control
// sequencer for commands, event retirement, division and interpolation
// ----------------------------------------------------------------------------
module pra_control (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  pra_pkg::t_dp_sts i_sts,
    output pra_pkg::t_dp_cmd o_cmd,
    output logic             o_busy,
    output logic             o_done
);
    import pra_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_CHK, S_DIV, S_MULF, S_MULP, S_RAMP, S_ADV,
        S_CMD, S_PUSH, S_FIN
    } t_state;

    t_state r_state, n_state;
    logic   r_done;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RD;
                end
            end
            S_RD: begin
                n_state = i_sts.is_tick ? S_CHK : S_CMD;
            end
            S_CHK: begin
                if (i_sts.head_retire) begin
                    o_cmd.retire = 1'b1;
                    n_state      = S_RD;
                end else if (i_sts.head_started) begin
                    o_cmd.div_init = 1'b1;
                    n_state        = S_DIV;
                end else begin
                    n_state = S_ADV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_MULF;
                end
            end
            S_MULF: begin
                o_cmd.mul_f = 1'b1;
                n_state     = S_MULP;
            end
            S_MULP: begin
                o_cmd.mul_p = 1'b1;
                n_state     = S_RAMP;
            end
            S_RAMP: begin
                o_cmd.ramp = 1'b1;
                n_state    = S_ADV;
            end
            S_ADV: begin
                o_cmd.adv = 1'b1;
                n_state   = S_FIN;
            end
            S_CMD: begin
                o_cmd.prep = 1'b1;
                n_state    = S_PUSH;
            end
            S_PUSH: begin
                o_cmd.push = 1'b1;
                n_state    = S_FIN;
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_FIN);
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

endmodule

FILE: sv/param_ramp_automation.sv
// ----------------------------------------------------------------------------
// param_ramp_automation
// parameter automation engine over a queue of up to 16 ramp events
// ----------------------------------------------------------------------------
// A word is taken when i_start is high and o_busy is low; its result word
// shows for one cycle on o_result with o_done, after the word has finished.
// Set, clear, apply and append pass through the command, push and finish
// states to o_done. A tick retires every event that has ended, one per pass
// through the read and check states, and when a ramp is running it forms
// the normalised ramp position in the bit-per-cycle divider, then runs the
// two registered multiplies and the final add.
// A result cannot be held off; o_busy stays low while o_done is shown.
module param_ramp_automation (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  pra_pkg::t_in_word  i_cmd,
    output logic               o_busy,
    output logic               o_done,
    output pra_pkg::t_out_word o_result
);
    import pra_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    pra_control u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (o_busy),
        .o_done  (o_done)
    );

    pra_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_word   (i_cmd),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts),
        .o_result (o_result)
    );

endmodule

FILE: sv/pra_checker.sv
// ----------------------------------------------------------------------------
// pra_checker
// port-level checks for the ramp automation engine
// ----------------------------------------------------------------------------
`include "param_ramp_automation_macros.svh"

module pra_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_start,
    input logic               i_busy,
    input logic               i_done,
    input pra_pkg::t_out_word i_result
);
    import pra_pkg::*;

    `PRA_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, i_start && !i_busy, i_busy)
    `PRA_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, i_done, !i_busy)
    `PRA_ASSERT_NXT(a_done_single, i_clk, i_rst_n, i_done, !i_done)
    `PRA_ASSERT_IMP(a_count_range, i_clk, i_rst_n, i_done,
        i_result.queued_events <= CNT_W'(QUEUE_DEPTH))
    `PRA_ASSERT_IMP(a_ramp_no_ovf, i_clk, i_rst_n, i_done && i_result.ramping,
        !i_result.queue_overflow && i_result.queued_events != '0)

endmodule

bind param_ramp_automation pra_checker u_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .i_busy   (o_busy),
    .i_done   (o_done),
    .i_result (o_result)
);

FILE: test/param_ramp_automation_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// param_ramp_automation_test
// self-checking bench for the ramp automation engine: directed and random
// command words are sent, a behavioural predictor works out each result word
// and a checker compares every o_done word with the oldest prediction
// ----------------------------------------------------------------------------
module param_ramp_automation_test;
    import pra_pkg::*;

    localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int EXP_DEPTH = 64;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_start;
    t_in_word   i_cmd;
    logic       o_busy;
    logic       o_done;
    t_out_word  o_result;

    param_ramp_automation u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_cmd    (i_cmd),
        .o_busy   (o_busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    // predictor state
    logic [47:0]        clk_now;
    logic signed [31:0] held;
    logic [47:0]        q_start [QUEUE_DEPTH];
    logic [47:0]        q_stop  [QUEUE_DEPTH];
    logic signed [31:0] q_from  [QUEUE_DEPTH];
    logic signed [31:0] q_to    [QUEUE_DEPTH];
    logic [1:0]         q_curve [QUEUE_DEPTH];
    int                 q_head;
    int                 q_count;

    t_out_word exp_mem [EXP_DEPTH];
    int        exp_wr;
    int        exp_rd;
    int        mismatches;
    int        idle_cycles;

    initial begin
        i_clk = 1'b0;
    end
    always #4 i_clk = ~i_clk;

    function automatic logic [47:0] sat_time(input logic [47:0] a, input logic [47:0] b);
        logic [48:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            sat_time = s[48] ? TIME_MAX : s[47:0];
        end
    endfunction

    function automatic logic signed [31:0] ramp_value(input int k, input logic [47:0] now);
        logic [47:0]  span;
        logic [63:0]  t;
        logic [63:0]  f;
        logic signed [63:0] d;
        logic signed [63:0] prod;
        logic signed [63:0] q;
        logic [63:0]  one;
        begin
            one  = 64'd1 << FRAC_BITS;
            span = q_stop[k] - q_start[k];
            if (span == 0) begin
                ramp_value = q_to[k];
            end else begin
                t = ({16'd0, now - q_start[k]} << FRAC_BITS) / {16'd0, span};
                if (t > one) t = one;
                if (q_curve[k] == CURVE_IN) f = (t * t) >> FRAC_BITS;
                else if (q_curve[k] == CURVE_OUT) f = (t * (2 * one - t)) >> FRAC_BITS;
                else f = t;
                d    = 64'(q_to[k]) - 64'(q_from[k]);
                prod = d * $signed(f);
                if (prod >= 0) q = prod >>> FRAC_BITS;
                else q = -$signed((64'(-prod) + one - 1) >> FRAC_BITS);
                ramp_value = 32'(64'(q_from[k]) + q);
            end
        end
    endfunction

    task automatic push_ramp(input logic [47:0] base, input logic signed [31:0] from,
                             input t_in_word w);
        int k;
        logic [47:0] st;
        begin
            k  = (q_head + q_count) % QUEUE_DEPTH;
            st = sat_time(base, 48'(w.delay_samples));
            q_start[k] = st;
            q_stop[k]  = sat_time(st, 48'(w.duration_samples));
            q_from[k]  = from;
            q_to[k]    = w.end_value;
            q_curve[k] = w.curve;
            q_count++;
        end
    endtask

    task automatic predict_word(input t_in_word w);
        t_out_word r;
        int last;
        logic [47:0] stop;
        begin
            r = '0;
            case (w.mode)
                MODE_TICK: begin
                    while (q_count > 0 && q_stop[q_head] <= clk_now) begin
                        held = q_to[q_head];
                        q_head = (q_head + 1) % QUEUE_DEPTH;
                        q_count--;
                    end
                    if (q_count > 0 && q_start[q_head] <= clk_now) begin
                        held = ramp_value(q_head, clk_now);
                        r.ramping = 1'b1;
                    end
                    clk_now = clk_now + 1;
                end
                MODE_APPLY, MODE_APPLY_HELD: begin
                    q_count = 0;
                    push_ramp(clk_now, w.mode == MODE_APPLY ? w.begin_value : held, w);
                end
                MODE_APPEND: begin
                    if (q_count >= QUEUE_DEPTH) begin
                        r.queue_overflow = 1'b1;
                    end else if (q_count == 0) begin
                        push_ramp(clk_now, held, w);
                    end else begin
                        last = (q_head + q_count - 1) % QUEUE_DEPTH;
                        push_ramp(q_stop[last], q_to[last], w);
                    end
                end
                MODE_SET: begin
                    q_count = 0;
                    held = w.begin_value;
                end
                MODE_CLEAR: begin
                    q_count = 0;
                end
                default: ;
            endcase
            r.value = held;
            r.queued_events = CNT_W'(q_count);
            if (q_count > 0) begin
                stop = q_stop[(q_head + q_count - 1) % QUEUE_DEPTH];
                if (stop > clk_now)
                    r.remaining_samples = (stop - clk_now > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                                                       : 32'(stop - clk_now);
            end
            exp_mem[exp_wr % EXP_DEPTH] = r;
            exp_wr++;
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_done) begin
            if (exp_wr == exp_rd) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %h", o_result);
            end else begin
                want = exp_mem[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (o_result.value !== want.value
                        || o_result.ramping !== want.ramping
                        || o_result.queued_events !== want.queued_events
                        || o_result.queue_overflow !== want.queue_overflow
                        || o_result.remaining_samples !== want.remaining_samples) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h actual %h", want, o_result);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_done) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic int gap_length();
        int n;
        begin
            n = $urandom_range(0, 9);
            if (n < 5) n = 0;
            else if (n < 9) n = $urandom_range(1, 3);
            else n = $urandom_range(10, 60);
            gap_length = n;
        end
    endfunction

    function automatic t_in_word make_word(input logic [2:0] mode, input int bv, input int ev,
                                           input int dly, input int dur, input logic [1:0] crv);
        t_in_word w;
        begin
            w.mode = mode;
            w.begin_value = bv;
            w.end_value = ev;
            w.delay_samples = dly[23:0];
            w.duration_samples = dur[23:0];
            w.curve = crv;
            make_word = w;
        end
    endfunction

    task automatic send_word(input t_in_word w);
        int n;
        begin
            i_start <= 1'b1;
            i_cmd   <= w;
            @(posedge i_clk);
            while (o_busy) @(posedge i_clk);
            predict_word(w);
            n = gap_length();
            if (n > 0) begin
                i_start <= 1'b0;
                i_cmd   <= make_word(3'($urandom), $urandom, $urandom, $urandom, $urandom,
                                     2'($urandom));
                repeat (n) @(posedge i_clk);
            end
        end
    endtask

    task automatic send_ticks(input int n);
        begin
            repeat (n) send_word(make_word(MODE_TICK, $urandom, $urandom, $urandom,
                                           $urandom, 2'($urandom)));
        end
    endtask

    task automatic wait_drained();
        begin
            i_start <= 1'b0;
            while (exp_wr != exp_rd) @(posedge i_clk);
        end
    endtask

    task automatic test_directed();
        begin
            send_word(make_word(MODE_SET, 32'h7FFF_FFFF, 0, 0, 0, 2'd0));
            send_word(make_word(MODE_APPLY, 32'h8000_0000, 32'h7FFF_FFFF, 0, 4, 2'd0));
            send_ticks(6);
            send_word(make_word(MODE_APPLY_HELD, 0, 32'h8000_0000, 1, 3, CURVE_IN));
            send_ticks(5);
            send_word(make_word(MODE_APPLY, 100, -100, 0, 0, CURVE_OUT));
            send_ticks(2);
            send_word(make_word(MODE_APPLY, 0, 65536, 2, 4, 2'd3));
            send_word(make_word(MODE_APPEND, 0, -65536, 1, 3, CURVE_OUT));
            send_ticks(3);
            send_word(make_word(MODE_APPLY, 5, 6, 24'hFF_FFFF, 24'hFF_FFFF, 2'd0));
            send_word(make_word(MODE_CLEAR, 0, 0, 0, 0, 2'd0));
            send_word(make_word(3'd6, 1, 2, 3, 4, 2'd1));
            send_word(make_word(3'd7, 1, 2, 3, 4, 2'd1));
        end
    endtask

    task automatic test_overflow();
        begin
            send_word(make_word(MODE_CLEAR, 0, 0, 0, 0, 2'd0));
            repeat (QUEUE_DEPTH + 2)
                send_word(make_word(MODE_APPEND, 0, $urandom, $urandom_range(0, 1),
                                    $urandom_range(0, 2), 2'($urandom_range(0, 3))));
            send_ticks(8);
            wait_drained();
        end
    endtask

    task automatic test_random_ramps();
        int i;
        int r;
        begin
            for (i = 0; i < 1150; i++) begin
                r = $urandom_range(0, 99);
                if (r < 55)
                    send_ticks(1);
                else if (r < 65)
                    send_word(make_word(MODE_APPLY, $urandom, $urandom, $urandom_range(0, 3),
                                        $urandom_range(0, 8), 2'($urandom_range(0, 3))));
                else if (r < 70)
                    send_word(make_word(MODE_APPLY_HELD, $urandom, $urandom,
                                        $urandom_range(0, 3), $urandom_range(0, 8),
                                        2'($urandom_range(0, 3))));
                else if (r < 88)
                    send_word(make_word(MODE_APPEND, $urandom, $urandom, $urandom_range(0, 3),
                                        $urandom_range(0, 6), 2'($urandom_range(0, 3))));
                else if (r < 91)
                    send_word(make_word(MODE_SET, $urandom, $urandom, $urandom, $urandom,
                                        2'($urandom)));
                else if (r < 93)
                    send_word(make_word(MODE_CLEAR, $urandom, $urandom, $urandom, $urandom,
                                        2'($urandom)));
                else if (r < 94)
                    send_word(make_word(3'($urandom_range(6, 7)), $urandom, $urandom,
                                        $urandom, $urandom, 2'($urandom)));
                else
                    send_word(make_word(MODE_APPEND, $urandom, $urandom, $urandom, $urandom,
                                        2'($urandom)));
                if (i == 600) wait_drained();
            end
        end
    endtask

    initial begin
        mismatches = 0;
        idle_cycles = 0;
        exp_wr = 0;
        exp_rd = 0;
        clk_now = '0;
        held = '0;
        q_head = 0;
        q_count = 0;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_cmd = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_overflow();
        test_random_ramps();
        wait_drained();
        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && exp_wr == exp_rd) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

FILE: param_ramp_automation.f
+incdir+sv
sv/pra_pkg.sv
sv/pra_datapath.sv
sv/pra_control.sv
sv/param_ramp_automation.sv
sv/pra_checker.sv
test/param_ramp_automation_test.sv
